### hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler: command
// codes, task states, priority constants and the controller/datapath links.
// ----------------------------------------------------------------------------
package pts_pkg;

	// task table geometry, settled by the 4-bit task slot field
	localparam int TASK_COUNT = 16;
	localparam int TASK_W     = 4;
	localparam int PRIO_W     = 4;
	localparam int CUR_PRIO_W = 5;
	localparam int MSG_W      = 8;

	// command codes
	localparam logic [3:0] ACT_INIT   = 4'd0;
	localparam logic [3:0] ACT_CREATE = 4'd1;
	localparam logic [3:0] ACT_READY  = 4'd2;
	localparam logic [3:0] ACT_WAIT   = 4'd3;
	localparam logic [3:0] ACT_START  = 4'd4;
	localparam logic [3:0] ACT_YIELD  = 4'd5;
	localparam logic [3:0] ACT_INTR   = 4'd6;
	localparam logic [3:0] ACT_SEND   = 4'd7;
	localparam logic [3:0] ACT_RECV   = 4'd8;

	// task states
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	// priority constants
	localparam logic [CUR_PRIO_W-1:0] PRIO_NONE  = 5'd16;
	localparam logic [PRIO_W-1:0]     PRIO_RESET = 4'd15;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan_step;
		logic commit;
	} pts_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_needed;
		logic scan_last;
	} pts_stat_t;

endpackage

### hw/rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer for the scheduler: takes a command transaction, runs the table
// scan where needed, then commits and hands the result to the output stage.
// ----------------------------------------------------------------------------
module pts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  pts_pkg::pts_stat_t stat,
	output pts_pkg::pts_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FIN    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	// output slot can take a result this cycle
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = stat.scan_needed ? S_SCAN : S_FIN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/pts_datapath.sv
// ----------------------------------------------------------------------------
// pts_datapath
// Task tables, mailboxes, running task registers, the serial best-task scan
// and the result registers of the scheduler.
// ----------------------------------------------------------------------------
module pts_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pts_pkg::pts_cmd_t                    cmd,
	output pts_pkg::pts_stat_t                   stat,
	input  logic [3:0]                           action,
	input  logic [pts_pkg::TASK_W-1:0]           task_id,
	input  logic [pts_pkg::PRIO_W-1:0]           priority_req,
	input  logic [1:0]                           task_state,
	input  logic [pts_pkg::MSG_W-1:0]            message,
	output logic                                 outcome,
	output logic [pts_pkg::TASK_W-1:0]           current_task,
	output logic [pts_pkg::CUR_PRIO_W-1:0]       current_priority
);

	// task tables
	logic [1:0]                       state_q   [pts_pkg::TASK_COUNT];
	logic [pts_pkg::PRIO_W-1:0]       prio_q    [pts_pkg::TASK_COUNT];
	logic                             mb_full_q [pts_pkg::TASK_COUNT];
	logic [pts_pkg::MSG_W-1:0]        mb_val_q  [pts_pkg::TASK_COUNT];

	// running task
	logic [pts_pkg::TASK_W-1:0]       run_q;
	logic [pts_pkg::CUR_PRIO_W-1:0]   run_pr_q;

	// latched command transaction
	logic [3:0]                       act_q;
	logic [pts_pkg::TASK_W-1:0]       tid_q;
	logic [pts_pkg::PRIO_W-1:0]       prio_req_q;
	logic [1:0]                       st_req_q;
	logic [pts_pkg::MSG_W-1:0]        msg_q;

	// scan
	logic [pts_pkg::TASK_W-1:0]       idx_q;
	logic [pts_pkg::TASK_W-1:0]       best_id_q;
	logic [pts_pkg::CUR_PRIO_W-1:0]   best_pr_q;
	logic                             scan_hit;

	// commit decisions
	logic [pts_pkg::TASK_W-1:0]       mb_addr;
	logic                             mb_full_rd;
	logic                             outcome_d;
	logic                             run_we;
	logic                             st_we;
	logic [pts_pkg::TASK_W-1:0]       st_addr;
	logic [1:0]                       st_wdata;
	logic                             prio_we;
	logic                             clear_all;
	logic                             mb_set;
	logic                             mb_clr;
	logic [pts_pkg::TASK_W-1:0]       run_d;
	logic [pts_pkg::CUR_PRIO_W-1:0]   run_pr_d;

	// scan status
	assign stat.scan_needed = (act_q == pts_pkg::ACT_START) ||
	                          (act_q == pts_pkg::ACT_YIELD) ||
	                          (act_q == pts_pkg::ACT_INTR);
	assign stat.scan_last   = (idx_q == pts_pkg::TASK_W'(pts_pkg::TASK_COUNT - 1));

	// one table entry compared per cycle
	assign scan_hit = (state_q[idx_q] == pts_pkg::ST_READY) &&
	                  ({1'b0, prio_q[idx_q]} < best_pr_q);

	// mailbox port: send addresses the target, receive the running task
	assign mb_addr    = (act_q == pts_pkg::ACT_SEND) ? tid_q : run_q;
	assign mb_full_rd = mb_full_q[mb_addr];

	// command decode at commit
	always_comb begin
		outcome_d = 1'b0;
		run_we    = 1'b0;
		st_we     = 1'b0;
		st_addr   = tid_q;
		st_wdata  = pts_pkg::ST_READY;
		prio_we   = 1'b0;
		clear_all = 1'b0;
		mb_set    = 1'b0;
		mb_clr    = 1'b0;
		unique case (act_q)
			pts_pkg::ACT_INIT: begin
				clear_all = 1'b1;
			end
			pts_pkg::ACT_CREATE: begin
				st_we    = 1'b1;
				st_wdata = st_req_q;
				prio_we  = 1'b1;
			end
			pts_pkg::ACT_READY: begin
				st_we = 1'b1;
			end
			pts_pkg::ACT_WAIT: begin
				st_we    = 1'b1;
				st_addr  = run_q;
				st_wdata = pts_pkg::ST_WAIT;
			end
			pts_pkg::ACT_START: begin
				run_we    = 1'b1;
				outcome_d = 1'b1;
			end
			pts_pkg::ACT_YIELD: begin
				if (best_id_q != run_q) begin
					run_we    = 1'b1;
					outcome_d = 1'b1;
				end
			end
			pts_pkg::ACT_INTR: begin
				if (best_id_q != run_q) begin
					run_we    = 1'b1;
					outcome_d = 1'b1;
					st_we     = 1'b1;
					st_addr   = run_q;
				end
			end
			pts_pkg::ACT_SEND: begin
				if (!mb_full_rd) begin
					mb_set    = 1'b1;
					st_we     = 1'b1;
					outcome_d = 1'b1;
				end
			end
			pts_pkg::ACT_RECV: begin
				if (mb_full_rd && (mb_val_q[run_q] == msg_q)) begin
					mb_clr    = 1'b1;
					outcome_d = 1'b1;
				end
			end
			default: begin
				outcome_d = 1'b0;
			end
		endcase
		run_d    = run_we ? best_id_q : run_q;
		run_pr_d = run_we ? best_pr_q : run_pr_q;
	end

	// tables, running task and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pts_pkg::TASK_COUNT; i++) begin
				state_q[i]   <= pts_pkg::ST_EMPTY;
				prio_q[i]    <= pts_pkg::PRIO_RESET;
				mb_full_q[i] <= 1'b0;
			end
			run_q     <= '0;
			run_pr_q  <= '0;
			idx_q     <= '0;
			best_id_q <= '0;
			best_pr_q <= '0;
		end else begin
			// scan start: interrupt begins from the running task
			if (cmd.load) begin
				idx_q <= '0;
				if (action == pts_pkg::ACT_INTR) begin
					best_id_q <= run_q;
					best_pr_q <= run_pr_q;
				end else begin
					best_id_q <= '0;
					best_pr_q <= pts_pkg::PRIO_NONE;
				end
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (scan_hit) begin
					best_id_q <= idx_q;
					best_pr_q <= {1'b0, prio_q[idx_q]};
				end
			end
			// table updates
			if (cmd.commit) begin
				if (clear_all) begin
					for (int i = 0; i < pts_pkg::TASK_COUNT; i++) begin
						state_q[i] <= pts_pkg::ST_EMPTY;
						prio_q[i]  <= pts_pkg::PRIO_RESET;
					end
				end
				if (st_we) begin
					state_q[st_addr] <= st_wdata;
				end
				if (prio_we) begin
					prio_q[tid_q] <= prio_req_q;
				end
				if (mb_set) begin
					mb_full_q[tid_q] <= 1'b1;
				end
				if (mb_clr) begin
					mb_full_q[run_q] <= 1'b0;
				end
				run_q    <= run_d;
				run_pr_q <= run_pr_d;
			end
		end
	end

	// command capture, mailbox data and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q      <= action;
			tid_q      <= task_id;
			prio_req_q <= priority_req;
			st_req_q   <= task_state;
			msg_q      <= message;
		end
		if (cmd.commit && mb_set) begin
			mb_val_q[tid_q] <= msg_q;
		end
		if (cmd.commit) begin
			outcome          <= outcome_d;
			current_task     <= run_d;
			current_priority <= run_pr_d;
		end
	end

endmodule

### hw/rtl/priority_task_scheduler.sv
// Flow: decode, then for start, yield and interrupt the one-entry-per-cycle
// scan of the sixteen task slots, then commit once the output slot is free.
// One command in work at a time; the next may enter while the result waits
// in the output register.
// Reset (arst_n low): all slots empty at priority 15, mailboxes empty,
// running task 0 at priority 0.
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Fixed-priority preemptive task scheduler with per-task one-slot mailboxes.
// ----------------------------------------------------------------------------
module priority_task_scheduler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic [3:0]                           action,
	input  logic [pts_pkg::TASK_W-1:0]           task_id,
	input  logic [pts_pkg::PRIO_W-1:0]           priority_req,
	input  logic [1:0]                           task_state,
	input  logic [pts_pkg::MSG_W-1:0]            message,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic                                 outcome,
	output logic [pts_pkg::TASK_W-1:0]           current_task,
	output logic [pts_pkg::CUR_PRIO_W-1:0]       current_priority
);

	pts_pkg::pts_cmd_t  cmd;
	pts_pkg::pts_stat_t stat;

	// sequencer
	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// tables and scan
	pts_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.action           (action),
		.task_id          (task_id),
		.priority_req     (priority_req),
		.task_state       (task_state),
		.message          (message),
		.outcome          (outcome),
		.current_task     (current_task),
		.current_priority (current_priority)
	);

endmodule

### tb/tb_priority_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler
// Self-checking bench for the priority task scheduler. A scoreboard object
// tracks the task table, mailboxes and the running task, and predicts the
// response to every accepted command. Responses are compared in order, field
// by field. A directed opening covers the corner cases. Random traffic follows
// under three idle profiles, and the response queue is drained between them.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler;
	import pts_pkg::*;

	// expected response of one command
	typedef struct {
		bit                  outcome;
		bit [TASK_W-1:0]     task_no;
		bit [CUR_PRIO_W-1:0] prio;
	} sched_reply_t;

	// tracks scheduler state and the responses still owed
	class sched_scoreboard;
		bit [1:0]            slot_state [TASK_COUNT];
		bit [PRIO_W-1:0]     slot_prio [TASK_COUNT];
		bit                  mbox_full [TASK_COUNT];
		bit [MSG_W-1:0]      mbox_byte [TASK_COUNT];
		bit [TASK_W-1:0]     run_task;
		bit [CUR_PRIO_W-1:0] run_prio;
		sched_reply_t        due_replies[$];
		int errors, commands, switches, deliveries, receipts;

		function new();
			clear_slots();
			foreach (mbox_full[i]) begin
				mbox_full[i] = 1'b0;
				mbox_byte[i] = '0;
			end
			run_task = '0;
			run_prio = '0;
			errors = 0;
			commands = 0;
			switches = 0;
			deliveries = 0;
			receipts = 0;
		endfunction

		function void clear_slots();
			foreach (slot_state[i]) begin
				slot_state[i] = ST_EMPTY;
				slot_prio[i]  = PRIO_RESET;
			end
		endfunction

		// best ready slot; only a strictly smaller priority beats the starting pick
		function void best_ready(input bit [TASK_W-1:0] from_task,
				input bit [CUR_PRIO_W-1:0] from_prio,
				output bit [TASK_W-1:0] win_task, output bit [CUR_PRIO_W-1:0] win_prio);
			win_task = from_task;
			win_prio = from_prio;
			for (int i = 0; i < TASK_COUNT; i++) begin
				if (slot_state[i] == ST_READY && {1'b0, slot_prio[i]} < win_prio) begin
					win_prio = {1'b0, slot_prio[i]};
					win_task = TASK_W'(i);
				end
			end
		endfunction

		// update the model for one accepted command and queue its response
		function void apply_command(input bit [3:0] act, input bit [TASK_W-1:0] tid,
				input bit [PRIO_W-1:0] prio, input bit [1:0] st, input bit [MSG_W-1:0] msg);
			sched_reply_t        r;
			bit [TASK_W-1:0]     wt;
			bit [CUR_PRIO_W-1:0] wp;
			r.outcome = 1'b0;
			case (act)
				ACT_INIT: clear_slots();
				ACT_CREATE: begin
					slot_state[tid] = st;
					slot_prio[tid]  = prio;
				end
				ACT_READY: slot_state[tid] = ST_READY;
				ACT_WAIT: slot_state[run_task] = ST_WAIT;
				ACT_START: begin
					best_ready('0, PRIO_NONE, wt, wp);
					run_task  = wt;
					run_prio  = wp;
					r.outcome = 1'b1;
				end
				ACT_YIELD: begin
					best_ready('0, PRIO_NONE, wt, wp);
					// same winner keeps the old running priority
					if (wt != run_task) begin
						run_task  = wt;
						run_prio  = wp;
						r.outcome = 1'b1;
					end
				end
				ACT_INTR: begin
					best_ready(run_task, run_prio, wt, wp);
					// preempted task goes back to ready
					if (wt != run_task) begin
						slot_state[run_task] = ST_READY;
						run_task  = wt;
						run_prio  = wp;
						r.outcome = 1'b1;
					end
				end
				ACT_SEND: begin
					if (!mbox_full[tid]) begin
						mbox_byte[tid]  = msg;
						mbox_full[tid]  = 1'b1;
						slot_state[tid] = ST_READY;
						r.outcome = 1'b1;
						deliveries++;
					end
				end
				ACT_RECV: begin
					if (mbox_full[run_task] && mbox_byte[run_task] == msg) begin
						mbox_full[run_task] = 1'b0;
						r.outcome = 1'b1;
						receipts++;
					end
				end
				default: ;
			endcase
			if (r.outcome && (act == ACT_START || act == ACT_YIELD || act == ACT_INTR))
				switches++;
			r.task_no = run_task;
			r.prio    = run_prio;
			due_replies.push_back(r);
			commands++;
		endfunction

		task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
			$display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		// compare one accepted response against the oldest expectation
		task compare_response(input logic got_outcome, input logic [TASK_W-1:0] got_task,
				input logic [CUR_PRIO_W-1:0] got_prio);
			sched_reply_t r;
			if (due_replies.size() == 0) begin
				report_mismatch("response with nothing pending, task", 32'(got_task), 32'd0);
			end else begin
				r = due_replies.pop_front();
				if (got_outcome !== r.outcome)
					report_mismatch("outcome", 32'(got_outcome), 32'(r.outcome));
				if (got_task !== r.task_no)
					report_mismatch("current_task", 32'(got_task), 32'(r.task_no));
				if (got_prio !== r.prio)
					report_mismatch("current_priority", 32'(got_prio), 32'(r.prio));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	logic [3:0]            action = '0;
	logic [TASK_W-1:0]     task_id = '0;
	logic [PRIO_W-1:0]     priority_req = '0;
	logic [1:0]            task_state = '0;
	logic [MSG_W-1:0]      message = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic                  outcome;
	logic [TASK_W-1:0]     current_task;
	logic [CUR_PRIO_W-1:0] current_priority;

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	sched_scoreboard sb;

	priority_task_scheduler uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.action           (action),
		.task_id          (task_id),
		.priority_req     (priority_req),
		.task_state       (task_state),
		.message          (message),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.outcome          (outcome),
		.current_task     (current_task),
		.current_priority (current_priority)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// response side: check accepted transactions, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				sb.compare_response(outcome, current_task, current_priority);
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	// present one command, with a random gap first, and hold it until taken
	task automatic issue_command(input logic [3:0] act, input logic [TASK_W-1:0] tid,
			input logic [PRIO_W-1:0] prio, input logic [1:0] st, input logic [MSG_W-1:0] msg);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid    <= 1'b1;
		action       <= act;
		task_id      <= tid;
		priority_req <= prio;
		task_state   <= st;
		message      <= msg;
		do @(posedge clk); while (cmd_stall);
		sb.apply_command(act, tid, prio, st, msg);
	endtask

	// hold off until every owed response has come back
	task automatic drain_responses();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (sb.due_replies.size() != 0);
	endtask

	// random traffic, mostly meaningful scheduling sequences
	task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
		logic [3:0]        act;
		logic [TASK_W-1:0] tid;
		logic [PRIO_W-1:0] prio;
		logic [1:0]        st;
		logic [MSG_W-1:0]  msg;
		int                pick;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			tid  = TASK_W'($urandom_range(TASK_COUNT - 1));
			prio = PRIO_W'($urandom_range(15));
			st   = 2'($urandom_range(3));
			msg  = MSG_W'($urandom_range(255));
			pick = $urandom_range(99);
			if (pick < 2)
				act = ACT_INIT;
			else if (pick < 20)
				act = ACT_CREATE;
			else if (pick < 30)
				act = ACT_READY;
			else if (pick < 37)
				act = ACT_WAIT;
			else if (pick < 44)
				act = ACT_START;
			else if (pick < 56)
				act = ACT_YIELD;
			else if (pick < 68)
				act = ACT_INTR;
			else if (pick < 82)
				act = ACT_SEND;
			else if (pick < 96)
				act = ACT_RECV;
			else
				act = 4'($urandom_range(15, 9));
			// receives mostly aim at the byte waiting for the running task
			if (act == ACT_RECV && sb.mbox_full[sb.run_task] && $urandom_range(3) != 0)
				msg = sb.mbox_byte[sb.run_task];
			issue_command(act, tid, prio, st, msg);
		end
		drain_responses();
	endtask

	// main sequence
	initial begin
		sb = new();
		send_idle_pct = 35;
		rsp_stall_pct = 52;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: empty table, ties, odd state, mailbox cases
		issue_command(ACT_YIELD,  4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_INTR,   4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_START,  4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(4'd15,      4'd15, 4'd15, 2'd3,     8'hFF);
		issue_command(ACT_CREATE, 4'd15, 4'd0,  ST_WAIT,  8'h00);
		issue_command(ACT_CREATE, 4'd5,  4'd15, ST_READY, 8'h00);
		issue_command(ACT_CREATE, 4'd3,  4'd7,  2'd3,     8'h00);
		issue_command(ACT_CREATE, 4'd9,  4'd7,  ST_READY, 8'h00);
		issue_command(ACT_CREATE, 4'd12, 4'd7,  ST_READY, 8'h00);
		issue_command(ACT_INTR,   4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_YIELD,  4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_READY,  4'd15, 4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_YIELD,  4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_SEND,   4'd15, 4'd0,  ST_EMPTY, 8'hFF);
		issue_command(ACT_SEND,   4'd15, 4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_RECV,   4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_RECV,   4'd0,  4'd0,  ST_EMPTY, 8'hFF);
		issue_command(ACT_RECV,   4'd0,  4'd0,  ST_EMPTY, 8'hFF);
		issue_command(ACT_WAIT,   4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_SEND,   4'd0,  4'd0,  ST_EMPTY, 8'hA5);
		issue_command(ACT_INIT,   4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_START,  4'd0,  4'd0,  ST_EMPTY, 8'h00);
		issue_command(ACT_RECV,   4'd0,  4'd0,  ST_EMPTY, 8'hA5);
		issue_command(4'd9,       4'd6,  4'd9,  ST_WAIT,  8'h5A);
		issue_command(ACT_INTR,   4'd0,  4'd0,  ST_EMPTY, 8'h00);

		// random traffic under three idle profiles
		run_phase(360, 35, 52);
		run_phase(360, 52, 35);
		run_phase(360, 0, 0);

		// let any late response show up
		repeat (40) @(posedge clk);
		$display("covered %0d commands: directed corners, then random traffic",
			sb.commands);
		$display("under three idle profiles; %0d task switches, %0d messages delivered, %0d received",
			sb.switches, sb.deliveries, sb.receipts);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### priority_task_scheduler.f
hw/rtl/pts_pkg.sv
hw/rtl/pts_ctrl.sv
hw/rtl/pts_datapath.sv
hw/rtl/priority_task_scheduler.sv
tb/tb_priority_task_scheduler.sv
